// ----- rtl/core/tasmc_pkg.sv -----
// ----------------------------------------------------------------------------
// tasmc_pkg
// Types, codes, constants and the duty table of the two-axis servo controller.
// ----------------------------------------------------------------------------
package tasmc_pkg;

    localparam int AXES       = 2;
    localparam int ANGLE_W    = 8;
    localparam int DUR_W      = 16;
    localparam int DUTY_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = ANGLE_W + DUR_W;
    localparam int STEP_CNT_W = 5;

    localparam int MUL_STEPS  = ANGLE_W;
    localparam int DIV_STEPS  = PROD_W;

    localparam int unsigned PULSE_LOW_US  = 500;
    localparam int unsigned PULSE_HIGH_US = 2500;
    localparam int unsigned PULSE_SPAN_US = PULSE_HIGH_US - PULSE_LOW_US;
    localparam int unsigned FRAME_US      = 20000;
    localparam int unsigned ANGLE_SPAN    = 180;
    localparam int unsigned DUTY_BITS     = 16;
    localparam int          ANGLE_CODES   = 1 << ANGLE_W;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_JOG  = 2'd2;
    localparam logic [1:0] ACT_STOP = 2'd3;

    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORTEST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONGEST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd7;

    localparam logic [ANGLE_W-1:0] RST_X_MIN    = 8'd30;
    localparam logic [ANGLE_W-1:0] RST_X_MAX    = 8'd150;
    localparam logic [ANGLE_W-1:0] RST_Y_MIN    = 8'd95;
    localparam logic [ANGLE_W-1:0] RST_Y_MAX    = 8'd150;
    localparam logic [DUR_W-1:0]   RST_SHORTEST = 16'd50;
    localparam logic [DUR_W-1:0]   RST_LONGEST  = 16'd5000;
    localparam logic [ANGLE_W-1:0] RST_PERIOD   = 8'd10;
    localparam logic [ANGLE_W-1:0] RST_STEP     = 8'd1;
    localparam logic [ANGLE_W-1:0] RST_X_ANGLE  = 8'd90;
    localparam logic [ANGLE_W-1:0] RST_Y_ANGLE  = 8'd122;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef logic [DUTY_W-1:0] duty_lut_t [ANGLE_CODES];

    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] mag;
        logic [DUR_W-1:0]   el;
        logic [DUR_W-1:0]   len;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] quo;
    } md_rsp_t;

    function automatic duty_lut_t build_duty_lut();
        duty_lut_t   t;
        int unsigned p;
        for (int a = 0; a < ANGLE_CODES; a++)
        begin
            p    = PULSE_LOW_US + (int'(a) * PULSE_SPAN_US) / ANGLE_SPAN;
            t[a] = DUTY_W'((p << DUTY_BITS) / FRAME_US);
        end
        return t;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

// ----- rtl/core/tasmc_in_if.sv -----
// ----------------------------------------------------------------------------
// tasmc_in_if
// Command channel: action word with axis, angle, duration and jog direction.
// ----------------------------------------------------------------------------
interface tasmc_in_if
    import tasmc_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic                  servo;
    logic [ANGLE_W-1:0]    angle;
    logic [DUR_W-1:0]      move_ms;
    logic signed [1:0]     direction;

    modport source (output valid, output action, output servo, output angle,
                    output move_ms, output direction, input ready);
    modport sink   (input valid, input action, input servo, input angle,
                    input move_ms, input direction, output ready);
endinterface

// ----- rtl/core/tasmc_out_if.sv -----
// ----------------------------------------------------------------------------
// tasmc_out_if
// Result channel: per-axis angle, target, PWM duty and status word.
// ----------------------------------------------------------------------------
interface tasmc_out_if
    import tasmc_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic                  axis;
    logic [ANGLE_W-1:0]    current_angle;
    logic [ANGLE_W-1:0]    target_angle;
    logic [DUTY_W-1:0]     duty;
    logic                  moving;
    logic                  status;
    logic                  last;

    modport source (output valid, output axis, output current_angle,
                    output target_angle, output duty, output moving,
                    output status, output last, input ready);
    modport sink   (input valid, input axis, input current_angle,
                    input target_angle, input duty, input moving,
                    input status, input last, output ready);
endinterface

// ----- rtl/core/tasmc_muldiv.sv -----
// ----------------------------------------------------------------------------
// tasmc_muldiv
// Bit-serial mag*el/len: shift-add multiply, then restoring division.
// ----------------------------------------------------------------------------
module tasmc_muldiv
    import tasmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    logic                  busy_reg,  busy_next;
    logic                  div_reg,   div_next;
    logic                  done_reg,  done_next;
    logic [STEP_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [PROD_W-1:0]     prod_reg,  prod_next;
    logic [DUR_W-1:0]      rem_reg,   rem_next;
    logic [DUR_W-1:0]      el_reg,    el_next;
    logic [DUR_W-1:0]      len_reg,   len_next;

    logic [DUR_W:0]        hi_sum;
    logic [DUR_W:0]        shifted;
    logic                  qbit;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        el_next   = el_reg;
        len_next  = len_reg;

        hi_sum  = {1'b0, prod_reg[PROD_W-1:ANGLE_W]} +
                  (prod_reg[0] ? {1'b0, el_reg} : '0);
        shifted = {rem_reg, prod_reg[PROD_W-1]};
        qbit    = shifted >= {1'b0, len_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = 1'b0;
            cnt_next  = '0;
            prod_next = {{DUR_W{1'b0}}, req.mag};
            rem_next  = '0;
            el_next   = req.el;
            len_next  = req.len;
        end
        else if (busy_reg && !div_reg)
        begin
            prod_next = {hi_sum, prod_reg[ANGLE_W-1:1]};
            if (cnt_reg == STEP_CNT_W'(MUL_STEPS - 1))
            begin
                div_next = 1'b1;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? DUR_W'(shifted - {1'b0, len_reg}) : shifted[DUR_W-1:0];
            prod_next = {prod_reg[PROD_W-2:0], qbit};
            if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        el_reg   <= el_next;
        len_reg  <= len_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = prod_reg[ANGLE_W-1:0];

endmodule

// ----- rtl/core/two_axis_servo_motion_controller_top.sv -----
// ----------------------------------------------------------------------------
// two_axis_servo_motion_controller_top
// Two servo axes with jog, timed and tracking moves, a ms clock and PWM duty.
//
//   channel  dir  words per item        payload
//   cmd      in   1                     action, servo, angle, move_ms,
//                                       direction
//   res      out  1 (command), 2 (tick) axis, current_angle, target_angle,
//                                       duty, moving, status, last
//   cfg      in   write only            cfg_we, cfg_index, cfg_data
//
// One item at a time. A command passes S_IDLE, S_EMIT and S_OUT, where it waits
// for res.ready. A tick passes S_ADV, S_EMIT and S_OUT for each axis, plus S_WAIT
// for an axis in a timed move until the serial 8-step multiply and 24-step divide
// in tasmc_muldiv raise its done flag. cmd.ready is high only while idle. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module two_axis_servo_motion_controller_top
    import tasmc_pkg::*;
#(
    parameter int CLOCK_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tasmc_in_if.sink              cmd,
    tasmc_out_if.source           res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            state_reg,  state_next;
    logic                  ax_reg,     ax_next;
    logic                  tick_reg,   tick_next;
    logic                  status_reg, status_next;
    logic [CLOCK_BITS-1:0] clock_reg,  clock_next;

    logic [ANGLE_W-1:0]    lim_lo_reg [AXES];
    logic [ANGLE_W-1:0]    lim_hi_reg [AXES];
    logic [DUR_W-1:0]      shortest_reg;
    logic [DUR_W-1:0]      longest_reg;
    logic [ANGLE_W-1:0]    period_reg;
    logic [ANGLE_W-1:0]    step_reg;

    logic [ANGLE_W-1:0]    present_reg [AXES];
    logic [ANGLE_W-1:0]    goal_reg    [AXES];
    logic [ANGLE_W-1:0]    origin_reg  [AXES];
    logic                  jog_on_reg  [AXES];
    logic                  jog_up_reg  [AXES];
    logic [DUR_W-1:0]      len_reg     [AXES];
    logic [CLOCK_BITS-1:0] start_reg   [AXES];

    logic [ANGLE_W-1:0]    present_next;
    logic [ANGLE_W-1:0]    goal_next;
    logic [ANGLE_W-1:0]    origin_next;
    logic                  jog_on_next;
    logic                  jog_up_next;
    logic [DUR_W-1:0]      len_next;
    logic [CLOCK_BITS-1:0] start_next;
    logic                  axis_wr;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic                  out_axis_reg;
    logic [ANGLE_W-1:0]    out_cur_reg;
    logic [ANGLE_W-1:0]    out_tgt_reg;
    logic [DUTY_W-1:0]     out_duty_reg;
    logic                  out_moving_reg;
    logic                  out_status_reg;
    logic                  out_last_reg;

    logic                  sel;
    logic [ANGLE_W-1:0]    cur;
    logic [ANGLE_W-1:0]    goal;
    logic [ANGLE_W-1:0]    org;
    logic [ANGLE_W-1:0]    lo;
    logic [ANGLE_W-1:0]    hi;
    logic signed [9:0]     lo_s;
    logic signed [9:0]     hi_s;
    logic signed [9:0]     st_s;
    logic signed [9:0]     v;
    logic signed [9:0]     diff;
    logic [9:0]            mag;
    logic [CLOCK_BITS-1:0] el;
    logic                  el_big;
    logic [DUR_W-1:0]      dur_clamped;
    logic                  dir_ok;

    md_req_t               md_req;
    md_rsp_t               md_rsp;

    tasmc_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign sel  = (state_reg == S_IDLE) ? cmd.servo : ax_reg;
    assign cur  = present_reg[sel];
    assign goal = goal_reg[sel];
    assign org  = origin_reg[sel];
    assign lo   = lim_lo_reg[sel];
    assign hi   = lim_hi_reg[sel];
    assign lo_s = $signed({2'b00, lo});
    assign hi_s = $signed({2'b00, hi});
    assign st_s = $signed({2'b00, step_reg});

    assign el     = clock_reg - start_reg[sel];
    assign el_big = (el >> DUR_W) != '0;
    assign dur_clamped = (cmd.move_ms > longest_reg) ? longest_reg : cmd.move_ms;
    assign dir_ok = (cmd.direction == DIR_UP) || (cmd.direction == DIR_DOWN);

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        tick_next      = tick_reg;
        status_next    = status_reg;
        clock_next     = clock_reg;
        present_next   = cur;
        goal_next      = goal;
        origin_next    = org;
        jog_on_next    = jog_on_reg[sel];
        jog_up_next    = jog_up_reg[sel];
        len_next       = len_reg[sel];
        start_next     = start_reg[sel];
        axis_wr        = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;
        v              = '0;
        diff           = '0;
        mag            = '0;
        md_req.start   = 1'b0;
        md_req.mag     = '0;
        md_req.el      = el[DUR_W-1:0];
        md_req.len     = len_reg[sel];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    ax_next     = cmd.servo;
                    tick_next   = 1'b0;
                    status_next = 1'b0;
                    state_next  = S_EMIT;
                    case (cmd.action)
                        ACT_TICK:
                        begin
                            clock_next = clock_reg + CLOCK_BITS'(period_reg);
                            ax_next    = AXIS_X;
                            tick_next  = 1'b1;
                            state_next = S_ADV;
                        end
                        ACT_SET:
                        begin
                            if (cmd.angle < lo || cmd.angle > hi)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                axis_wr     = 1'b1;
                                jog_on_next = 1'b0;
                                goal_next   = cmd.angle;
                                if (cmd.move_ms != '0 &&
                                    cmd.move_ms >= shortest_reg)
                                begin
                                    origin_next = cur;
                                    len_next    = dur_clamped;
                                    start_next  = clock_reg;
                                end
                                else
                                begin
                                    len_next = '0;
                                end
                            end
                        end
                        ACT_JOG:
                        begin
                            if (!dir_ok)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                axis_wr     = 1'b1;
                                len_next    = '0;
                                jog_on_next = 1'b1;
                                jog_up_next = (cmd.direction == DIR_UP);
                                goal_next   = (cmd.direction == DIR_UP) ? hi : lo;
                            end
                        end
                        ACT_STOP:
                        begin
                            axis_wr     = 1'b1;
                            jog_on_next = 1'b0;
                            len_next    = '0;
                            goal_next   = cur;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADV:
            begin
                state_next = S_EMIT;
                if (jog_on_reg[sel])
                begin
                    axis_wr = 1'b1;
                    v = jog_up_reg[sel] ? $signed({2'b00, cur}) + st_s
                                        : $signed({2'b00, cur}) - st_s;
                    if (v > hi_s)
                    begin
                        v = hi_s;
                    end
                    else if (v < lo_s)
                    begin
                        v = lo_s;
                    end
                    present_next = v[ANGLE_W-1:0];
                end
                else if (len_reg[sel] != '0)
                begin
                    if (el_big || el[DUR_W-1:0] >= len_reg[sel])
                    begin
                        axis_wr      = 1'b1;
                        present_next = goal;
                        len_next     = '0;
                    end
                    else
                    begin
                        diff         = $signed({2'b00, goal}) - $signed({2'b00, org});
                        mag          = diff[9] ? 10'(-diff) : 10'(diff);
                        md_req.start = 1'b1;
                        md_req.mag   = mag[ANGLE_W-1:0];
                        state_next   = S_WAIT;
                    end
                end
                else
                begin
                    axis_wr = 1'b1;
                    diff    = $signed({2'b00, goal}) - $signed({2'b00, cur});
                    mag     = diff[9] ? 10'(-diff) : 10'(diff);
                    if (mag >= {2'b00, step_reg})
                    begin
                        v = (diff > 0) ? $signed({2'b00, cur}) + st_s
                                       : $signed({2'b00, cur}) - st_s;
                        present_next = v[ANGLE_W-1:0];
                    end
                    else
                    begin
                        present_next = goal;
                    end
                end
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    axis_wr = 1'b1;
                    diff    = $signed({2'b00, goal}) - $signed({2'b00, org});
                    v = diff[9] ? $signed({2'b00, org}) - $signed({2'b00, md_rsp.quo})
                                : $signed({2'b00, org}) + $signed({2'b00, md_rsp.quo});
                    if (v > hi_s)
                    begin
                        v = hi_s;
                    end
                    if (v < lo_s)
                    begin
                        v = lo_s;
                    end
                    present_next = v[ANGLE_W-1:0];
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    if (tick_reg && ax_reg != AXIS_Y)
                    begin
                        ax_next    = AXIS_Y;
                        state_next = S_ADV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ax_reg         <= AXIS_X;
            tick_reg       <= 1'b0;
            status_reg     <= 1'b0;
            clock_reg      <= '0;
            out_valid_reg  <= 1'b0;
            lim_lo_reg[0]  <= RST_X_MIN;
            lim_hi_reg[0]  <= RST_X_MAX;
            lim_lo_reg[1]  <= RST_Y_MIN;
            lim_hi_reg[1]  <= RST_Y_MAX;
            shortest_reg   <= RST_SHORTEST;
            longest_reg    <= RST_LONGEST;
            period_reg     <= RST_PERIOD;
            step_reg       <= RST_STEP;
            present_reg[0] <= RST_X_ANGLE;
            present_reg[1] <= RST_Y_ANGLE;
            goal_reg[0]    <= RST_X_ANGLE;
            goal_reg[1]    <= RST_Y_ANGLE;
            for (int i = 0; i < AXES; i++)
            begin
                jog_on_reg[i] <= 1'b0;
                jog_up_reg[i] <= 1'b0;
                len_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            tick_reg      <= tick_next;
            status_reg    <= status_next;
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
            if (axis_wr)
            begin
                present_reg[sel] <= present_next;
                goal_reg[sel]    <= goal_next;
                jog_on_reg[sel]  <= jog_on_next;
                jog_up_reg[sel]  <= jog_up_next;
                len_reg[sel]     <= len_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_X_MIN:    lim_lo_reg[0] <= cfg_data[ANGLE_W-1:0];
                    REG_X_MAX:    lim_hi_reg[0] <= cfg_data[ANGLE_W-1:0];
                    REG_Y_MIN:    lim_lo_reg[1] <= cfg_data[ANGLE_W-1:0];
                    REG_Y_MAX:    lim_hi_reg[1] <= cfg_data[ANGLE_W-1:0];
                    REG_SHORTEST: shortest_reg  <= cfg_data[DUR_W-1:0];
                    REG_LONGEST:  longest_reg   <= cfg_data[DUR_W-1:0];
                    REG_PERIOD:   period_reg    <= cfg_data[ANGLE_W-1:0];
                    REG_STEP:     step_reg      <= cfg_data[ANGLE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // origin and start are only read while a timed move is active
    always_ff @(posedge clk)
    begin
        if (axis_wr)
        begin
            origin_reg[sel] <= origin_next;
            start_reg[sel]  <= start_next;
        end
        if (out_load)
        begin
            out_axis_reg   <= ax_reg;
            out_cur_reg    <= present_reg[ax_reg];
            out_tgt_reg    <= goal_reg[ax_reg];
            out_duty_reg   <= DUTY_LUT[present_reg[ax_reg]];
            out_moving_reg <= (present_reg[ax_reg] != goal_reg[ax_reg]) ||
                              jog_on_reg[ax_reg] || (len_reg[ax_reg] != '0);
            out_status_reg <= status_reg;
            out_last_reg   <= !tick_reg || (ax_reg == AXIS_Y);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.axis          = out_axis_reg;
    assign res.current_angle = out_cur_reg;
    assign res.target_angle  = out_tgt_reg;
    assign res.duty          = out_duty_reg;
    assign res.moving        = out_moving_reg;
    assign res.status        = out_status_reg;
    assign res.last          = out_last_reg;

endmodule
